// ===== rtl/bpa_pkg.sv =====
// Shared types, constants and register indexes for the bitmap page allocator.
// No dependencies; bpa_ctrl and bitmap_page_allocator import this package, bpa_ram does not.
`default_nettype none

package bpa_pkg;

    localparam int DEF_MAX_PAGES = 32768;
    localparam int DEF_WORD_BITS = 32;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT   = CFG_IDX_W'(1);

    localparam logic [31:0] BASE_RESET       = 32'h0100_0000;
    localparam logic [15:0] PAGE_COUNT_RESET = 16'd28672;

    localparam int          PAGE_SHIFT = 12;
    localparam logic [11:0] PAGE_MASK  = 12'hfff;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_EMPTY   = 2'd1;
    localparam status_t ST_RANGE   = 2'd2;
    localparam status_t ST_ALREADY = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [31:0] free_address;
    } bpa_in_t;

    typedef struct packed {
        logic [31:0] page_address;
        status_t     status;
        logic [15:0] free_pages;
    } bpa_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_WR,
        S_FREE_CHK,
        S_FREE_MUL,
        S_FREE_FIX,
        S_FREE_RD,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/bpa_ram.sv =====
// Simple dual-port bitmap memory: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module bpa_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bpa_ctrl.sv =====
// Command sequencer: word scan for allocation, index split and read-modify-write for
// frees, configuration registers and the result register. Depends on bpa_pkg.
`default_nettype none

module bpa_ctrl #(
    parameter int MAX_PAGES = 32768,
    parameter int WORD_BITS = 32,
    parameter int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS,
    parameter int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire bpa_pkg::bpa_in_t                 s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output bpa_pkg::bpa_out_t                     m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                  mem_we,
    output logic      [ADDR_W-1:0]                mem_waddr,
    output logic      [WORD_BITS-1:0]             mem_wdata,
    output logic                                  mem_re,
    output logic      [ADDR_W-1:0]                mem_raddr,
    input  wire logic [WORD_BITS-1:0]             mem_rdata
);

    import bpa_pkg::*;

    localparam int WC_W      = $clog2(WORD_COUNT + 1);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int DIV_RECIP = 65536 / WORD_BITS;

    function automatic logic [15:0] clamp_pages(input logic [15:0] pc);
        if ({16'b0, pc} > 32'(MAX_PAGES)) begin
            return 16'(MAX_PAGES);
        end
        return pc;
    endfunction

    state_t            state_reg,    state_next;
    logic [31:0]       base_reg,     base_next;
    logic [15:0]       managed_reg,  managed_next;
    logic [15:0]       free_cnt_reg, free_cnt_next;
    logic [WC_W-1:0]   hwm_reg,      hwm_next;
    logic              m_valid_reg,  m_valid_next;
    logic              dvld_reg,     dvld_next;

    logic [31:0]       addr_reg,       addr_next;
    logic [WC_W-1:0]   iss_w_reg,      iss_w_next;
    logic [16:0]       iss_first_reg,  iss_first_next;
    logic [WC_W-1:0]   dw_reg,         dw_next;
    logic [15:0]       dfirst_reg,     dfirst_next;
    logic [ADDR_W-1:0] found_w_reg,    found_w_next;
    logic [WORD_BITS-1:0] found_word_reg, found_word_next;
    logic [15:0]       found_idx_reg,  found_idx_next;
    logic [15:0]       fidx_reg,       fidx_next;
    logic [15:0]       qest_reg,       qest_next;
    logic [BIT_W-1:0]  fbit_reg,       fbit_next;
    bpa_out_t          res_reg,        res_next;
    bpa_out_t          m_data_reg,     m_data_next;

    logic [WORD_BITS-1:0] word_eff;
    logic [WORD_BITS-1:0] vmask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] low_onehot;
    logic [BIT_W-1:0]     bit_idx;
    logic [15:0]          rem_m;
    logic                 can_issue;
    logic                 any_free;
    logic [31:0]          diff;
    logic [31:0]          recip_prod;
    logic [15:0]          qw;
    logic [15:0]          rem_f;
    logic [15:0]          q_fix;
    logic [15:0]          r_fix;

    // Words at or above the high-water mark were never written since the last clear and read as free.
    assign word_eff   = (dw_reg < hwm_reg) ? mem_rdata : '0;
    assign rem_m      = managed_reg - dfirst_reg;
    assign vmask      = (rem_m >= 16'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                                                   : ~({WORD_BITS{1'b1}} << rem_m);
    assign free_bits  = ~word_eff & vmask;
    assign any_free   = |free_bits;
    assign low_onehot = free_bits & (~free_bits + WORD_BITS'(1));
    assign can_issue  = (iss_w_reg < WC_W'(WORD_COUNT)) && (iss_first_reg < {1'b0, managed_reg});

    always_comb begin
        bit_idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (low_onehot[i]) begin
                bit_idx = bit_idx | BIT_W'(i);
            end
        end
    end

    // Page index split into word and bit: reciprocal estimate, then one correction step.
    assign diff       = addr_reg - base_reg;
    assign recip_prod = 32'(fidx_reg) * 32'(DIV_RECIP);
    assign qw         = 16'(32'(qest_reg) * 32'(WORD_BITS));
    assign rem_f      = fidx_reg - qw;
    assign q_fix      = (rem_f >= 16'(WORD_BITS)) ? qest_reg + 16'd1 : qest_reg;
    assign r_fix      = (rem_f >= 16'(WORD_BITS)) ? rem_f - 16'(WORD_BITS) : rem_f;

    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        managed_next    = managed_reg;
        free_cnt_next   = free_cnt_reg;
        hwm_next        = hwm_reg;
        m_valid_next    = m_valid_reg;
        dvld_next       = dvld_reg;
        addr_next       = addr_reg;
        iss_w_next      = iss_w_reg;
        iss_first_next  = iss_first_reg;
        dw_next         = dw_reg;
        dfirst_next     = dfirst_reg;
        found_w_next    = found_w_reg;
        found_word_next = found_word_reg;
        found_idx_next  = found_idx_reg;
        fidx_next       = fidx_reg;
        qest_next       = qest_reg;
        fbit_next       = fbit_reg;
        res_next        = res_reg;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = found_w_reg;
        mem_wdata       = found_word_reg;
        mem_re          = 1'b0;
        mem_raddr       = iss_w_reg[ADDR_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    addr_next = s_data.free_address;
                    if (s_data.cmd == CMD_FREE) begin
                        state_next = S_FREE_CHK;
                    end else if (free_cnt_reg == 16'd0) begin
                        res_next   = '{page_address: 32'd0, status: ST_EMPTY,
                                       free_pages: free_cnt_reg};
                        state_next = S_RESP;
                    end else begin
                        iss_w_next     = '0;
                        iss_first_next = '0;
                        dvld_next      = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                dvld_next = 1'b0;
                if (can_issue) begin
                    mem_re         = 1'b1;
                    mem_raddr      = iss_w_reg[ADDR_W-1:0];
                    iss_w_next     = iss_w_reg + WC_W'(1);
                    iss_first_next = iss_first_reg + 17'(WORD_BITS);
                    dvld_next      = 1'b1;
                    dw_next        = iss_w_reg;
                    dfirst_next    = iss_first_reg[15:0];
                end
                if (dvld_reg && any_free) begin
                    found_w_next    = dw_reg[ADDR_W-1:0];
                    found_word_next = word_eff | low_onehot;
                    found_idx_next  = dfirst_reg + 16'(bit_idx);
                    state_next      = S_ALLOC_WR;
                end else if (!dvld_reg && !can_issue) begin
                    res_next   = '{page_address: 32'd0, status: ST_EMPTY,
                                   free_pages: free_cnt_reg};
                    state_next = S_RESP;
                end
            end
            S_ALLOC_WR: begin
                mem_we    = 1'b1;
                mem_waddr = found_w_reg;
                mem_wdata = found_word_reg;
                if (WC_W'(found_w_reg) >= hwm_reg) begin
                    hwm_next = WC_W'(found_w_reg) + WC_W'(1);
                end
                free_cnt_next = free_cnt_reg - 16'd1;
                res_next   = '{page_address: base_reg + {4'b0, found_idx_reg, 12'b0},
                               status: ST_OK, free_pages: free_cnt_reg - 16'd1};
                state_next = S_RESP;
            end
            S_FREE_CHK: begin
                if ((addr_reg[11:0] & PAGE_MASK) != 12'd0
                    || diff[31:PAGE_SHIFT] >= {4'b0, managed_reg}) begin
                    res_next   = '{page_address: 32'd0, status: ST_RANGE,
                                   free_pages: free_cnt_reg};
                    state_next = S_RESP;
                end else begin
                    fidx_next  = diff[27:PAGE_SHIFT];
                    state_next = S_FREE_MUL;
                end
            end
            S_FREE_MUL: begin
                qest_next  = recip_prod[31:16];
                state_next = S_FREE_FIX;
            end
            S_FREE_FIX: begin
                mem_re       = 1'b1;
                mem_raddr    = q_fix[ADDR_W-1:0];
                dw_next      = WC_W'(q_fix);
                found_w_next = q_fix[ADDR_W-1:0];
                fbit_next    = r_fix[BIT_W-1:0];
                state_next   = S_FREE_RD;
            end
            S_FREE_RD: begin
                if (!word_eff[fbit_reg]) begin
                    res_next = '{page_address: 32'd0, status: ST_ALREADY,
                                 free_pages: free_cnt_reg};
                end else begin
                    mem_we        = 1'b1;
                    mem_waddr     = found_w_reg;
                    mem_wdata     = word_eff & ~(WORD_BITS'(1) << fbit_reg);
                    free_cnt_next = free_cnt_reg + 16'd1;
                    res_next      = '{page_address: 32'd0, status: ST_OK,
                                      free_pages: free_cnt_reg + 16'd1};
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A page_count write restarts the bitmap: the high-water mark drops to zero.
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_BASE_ADDRESS) begin
                base_next = {cfg_data[31:PAGE_SHIFT], 12'b0};
            end else if (cfg_index == REG_PAGE_COUNT) begin
                managed_next  = clamp_pages(cfg_data[15:0]);
                free_cnt_next = clamp_pages(cfg_data[15:0]);
                hwm_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            base_reg     <= BASE_RESET;
            managed_reg  <= clamp_pages(PAGE_COUNT_RESET);
            free_cnt_reg <= clamp_pages(PAGE_COUNT_RESET);
            hwm_reg      <= '0;
            m_valid_reg  <= 1'b0;
            dvld_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            managed_reg  <= managed_next;
            free_cnt_reg <= free_cnt_next;
            hwm_reg      <= hwm_next;
            m_valid_reg  <= m_valid_next;
            dvld_reg     <= dvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        iss_w_reg      <= iss_w_next;
        iss_first_reg  <= iss_first_next;
        dw_reg         <= dw_next;
        dfirst_reg     <= dfirst_next;
        found_w_reg    <= found_w_next;
        found_word_reg <= found_word_next;
        found_idx_reg  <= found_idx_next;
        fidx_reg       <= fidx_next;
        qest_reg       <= qest_next;
        fbit_reg       <= fbit_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != S_IDLE)
        else $error("accepted command did not start processing");

    a_free_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= managed_reg)
        else $error("free count exceeds managed pages");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_ALLOC_WR || state_reg == S_FREE_RD))
        else $error("bitmap written outside a write state");

    a_write_below_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> WC_W'(mem_waddr) <= hwm_reg)
        else $error("bitmap write skips past the high-water mark");

    a_hwm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hwm_reg <= WC_W'(WORD_COUNT))
        else $error("high-water mark beyond bitmap depth");

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_allocator.sv =====
// Bitmap page frame allocator: one used/free bit per 4 KB page, kept in a word memory.
// Command beats enter on s_*, one result beat per command leaves on m_*, and registers
// base_address (index 0) and page_count (index 1) are written through cfg_*.
// Allocate scans bitmap words from word zero, one memory read per cycle, and takes the
// lowest free page; the found word is written back with that bit set, the result goes to
// the result register, and the next command beat can be taken once the block is back in
// idle. A free runs through the address check, the word/bit split in two steps, one
// memory read with the write-back, and the result register. A refused address goes from
// the check straight to the result register, and an allocate on an empty pool goes there
// directly.
// One command is in flight at a time; the next command beat is taken as soon as the
// previous result sits in the output register, even while the receiver stalls it.
// Reset and every page_count write mark all pages free at once through a high-water
// mark over the written words, so there is no clearing pass and no dead time after reset.
// Failures (no free page, bad address, double free) return a status code and leave the
// bitmap and the free count untouched. Configuration is to be written only while idle;
// the block itself does not enforce it. Depends on bpa_pkg, bpa_ctrl and bpa_ram.
`default_nettype none

module bitmap_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES,
    parameter int WORD_BITS = bpa_pkg::DEF_WORD_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire bpa_pkg::bpa_in_t                 s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output bpa_pkg::bpa_out_t                     m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import bpa_pkg::*;

    localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    bpa_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .WORD_BITS (WORD_BITS),
        .WORD_COUNT(WORD_COUNT),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re   (mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    bpa_ram #(
        .DEPTH (WORD_COUNT),
        .WIDTH (WORD_BITS),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

endmodule

`default_nettype wire

// ===== sim/bpa_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the bitmap page allocator: keeps its own used-page bitmap and registers,
// predicts the result of every accepted command beat and compares the result beats.
// Depends on bpa_pkg only; it is instantiated next to the block by the test top.
module bpa_checker #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  wire bpa_pkg::bpa_in_t                 s_data,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    input  wire bpa_pkg::bpa_out_t                m_data,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                    mismatches,
    output int                                    outstanding,
    output int                                    checked,
    output int                                    n_empty,
    output int                                    n_bad_addr,
    output int                                    n_double_free
);
    import bpa_pkg::*;

    bit          page_used [MAX_PAGES];
    logic [31:0] win_base;
    logic [15:0] count_reg;
    logic [15:0] free_count;
    bpa_out_t    expected_results [$];

    // A page_count above the built capacity is clipped to it.
    function automatic int managed_pages();
        return (int'(count_reg) > MAX_PAGES) ? MAX_PAGES : int'(count_reg);
    endfunction

    function automatic void release_all_pages();
        foreach (page_used[i]) page_used[i] = 1'b0;
        free_count = 16'(managed_pages());
    endfunction

    function automatic bpa_out_t predict_command(input bpa_in_t beat);
        bpa_out_t    res;
        logic [31:0] idx;
        int          hit;
        res = '0;
        res.status = ST_OK;
        if (beat.cmd == CMD_ALLOC) begin
            hit = -1;
            if (free_count != 0) begin
                for (int i = 0; i < managed_pages() && hit < 0; i++) begin
                    if (!page_used[i]) hit = i;
                end
            end
            if (hit < 0) begin
                res.status = ST_EMPTY;
            end else begin
                page_used[hit] = 1'b1;
                free_count = free_count - 16'd1;
                // The address wraps modulo 2^32 when the window runs past the top.
                res.page_address = win_base + (32'(hit) << PAGE_SHIFT);
            end
        end else begin
            idx = (beat.free_address - win_base) >> PAGE_SHIFT;
            if ((beat.free_address[11:0] & PAGE_MASK) != '0 || idx >= 32'(managed_pages())) begin
                res.status = ST_RANGE;
            end else if (!page_used[idx]) begin
                res.status = ST_ALREADY;
            end else begin
                page_used[idx] = 1'b0;
                free_count = free_count + 16'd1;
            end
        end
        res.free_pages = free_count;
        return res;
    endfunction

    always @(posedge aclk) begin
        bpa_out_t want;
        if (!aresetn) begin
            win_base = BASE_RESET;
            count_reg = PAGE_COUNT_RESET;
            release_all_pages();
            expected_results.delete();
            mismatches <= 0;
            checked <= 0;
            n_empty <= 0;
            n_bad_addr <= 0;
            n_double_free <= 0;
        end else begin
            // The result side is checked first, so a stray beat is never matched
            // against a command taken at the same edge.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with no command waiting: addr %h status %0d free %0d",
                             $time, m_data.page_address, m_data.status, m_data.free_pages);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    checked <= checked + 1;
                    if (want.status == ST_EMPTY) n_empty <= n_empty + 1;
                    if (want.status == ST_RANGE) n_bad_addr <= n_bad_addr + 1;
                    if (want.status == ST_ALREADY) n_double_free <= n_double_free + 1;
                    if (m_data.page_address !== want.page_address ||
                        m_data.status !== want.status ||
                        m_data.free_pages !== want.free_pages) begin
                        $display("%0t: mismatch: expected addr %h status %0d free %0d, got addr %h status %0d free %0d",
                                 $time, want.page_address, want.status, want.free_pages,
                                 m_data.page_address, m_data.status, m_data.free_pages);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_valid && s_ready) expected_results.push_back(predict_command(s_data));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BASE_ADDRESS: win_base = {cfg_data[31:12], 12'h000};
                    REG_PAGE_COUNT: begin
                        count_reg = cfg_data[15:0];
                        release_all_pages();
                    end
                    default: ;
                endcase
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

// ===== sim/bitmap_page_allocator_test.sv =====
`timescale 1ns / 1ps
// Test top for the bitmap page allocator: clock, reset, command and register stimulus
// and the verdict. Depends on bpa_pkg, bitmap_page_allocator and bpa_checker.
module bitmap_page_allocator_test;
    import bpa_pkg::*;

    localparam int MAX_PAGES    = DEF_MAX_PAGES;
    localparam int WORD_BITS    = DEF_WORD_BITS;
    localparam int DRAIN_CYCLES = MAX_PAGES / WORD_BITS + 16;
    localparam int HOLD_CYCLES  = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    bpa_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    bpa_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int checked;
    int n_empty;
    int n_bad_addr;
    int n_double_free;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_ticket   = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int commands_sent = 0;
    int settings_used = 1;

    // Window as last written, used only to aim frees at managed pages and just past them.
    logic [31:0] win_base  = BASE_RESET;
    int          win_pages = PAGE_COUNT_RESET;

    bitmap_page_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bpa_checker #(.MAX_PAGES(MAX_PAGES)) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .checked       (checked),
        .n_empty       (n_empty),
        .n_bad_addr    (n_bad_addr),
        .n_double_free (n_double_free)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Result side: random stalls, or a long hold-off whenever a new one is requested.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_ticket) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_ticket;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    function automatic logic [31:0] page_addr(input int idx);
        return win_base + (32'(idx) << PAGE_SHIFT);
    endfunction

    // Valid is only dropped for an idle gap before a beat, so back-to-back beats keep it high.
    task automatic send_cmd(input logic op, input logic [31:0] addr);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < snd_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{cmd: op, free_address: addr};
        commands_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_alloc();
        send_cmd(CMD_ALLOC, $urandom());
    endtask

    task automatic send_free(input logic [31:0] addr);
        send_cmd(CMD_FREE, addr);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_BASE_ADDRESS) begin
            win_base = {value[31:12], 12'h000};
        end else if (idx == REG_PAGE_COUNT) begin
            win_pages = (int'(value[15:0]) > MAX_PAGES) ? MAX_PAGES : int'(value[15:0]);
        end
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly allocations and frees of managed pages, some just past the end, some noise.
    task automatic random_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) send_alloc();
        else if (pick < 85) send_free(page_addr($urandom_range(0, win_pages - 1)));
        else if (pick < 92) send_free(page_addr(win_pages + $urandom_range(0, 7)));
        else send_free($urandom());
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset window: lowest-page reuse, double free and the address checks.
        send_alloc();
        send_alloc();
        send_free(BASE_RESET);
        send_free(BASE_RESET);
        send_alloc();
        send_free(BASE_RESET + 32'h1);
        send_free(BASE_RESET - 32'h1000);
        send_free(page_addr(PAGE_COUNT_RESET));
        send_free(page_addr(PAGE_COUNT_RESET - 1));
        send_free(32'hffff_ffff);
        send_free(32'h0000_0000);

        // Moving the base keeps the bitmap; page zero is still in use.
        settle();
        write_reg(REG_BASE_ADDRESS, 32'hffff_ffff);
        end_writes();
        send_free(32'hffff_f000);
        send_alloc();

        // Two pages at the top of the address space: the second one wraps to zero.
        settle();
        write_reg(REG_PAGE_COUNT, 32'd2);
        end_writes();
        send_alloc();
        send_alloc();
        send_alloc();
        send_free(32'h0000_0000);
        send_free(32'h0000_1000);
        send_alloc();

        settle();
        write_reg(REG_PAGE_COUNT, 32'd0);
        end_writes();
        send_alloc();
        send_free(32'hffff_f000);

        // A write to an unknown index must change nothing.
        settle();
        write_reg(CFG_IDX_W'(4'hf), 32'hffff_ffff);
        write_reg(REG_BASE_ADDRESS, 32'h0000_0000);
        write_reg(REG_PAGE_COUNT, 32'd1);
        end_writes();
        send_alloc();
        send_alloc();
        send_free(32'h0000_0000);
        send_free(32'h0000_0000);

        // Oversized page_count is clipped to the built capacity.
        settle();
        write_reg(REG_BASE_ADDRESS, 32'h1234_5abc);
        write_reg(REG_PAGE_COUNT, 32'hffff_ffff);
        end_writes();
        send_alloc();
        send_free(page_addr(MAX_PAGES - 1));
        send_free(page_addr(MAX_PAGES));

        for (int mode = 0; mode < 3; mode++) begin
            snd_idle_pct <= (mode == 0) ? 10 : (mode == 1) ? 87 : 0;
            rcv_stall_pct <= (mode == 0) ? 87 : (mode == 1) ? 10 : 0;
            for (int round = 0; round < 4; round++) begin
                settle();
                write_reg(REG_BASE_ADDRESS, $urandom());
                if (round < 3) write_reg(REG_PAGE_COUNT, $urandom_range(1, 64));
                else if (mode == 0) write_reg(REG_PAGE_COUNT, 32'h0000_8000);
                else write_reg(REG_PAGE_COUNT,
                               {16'($urandom()), 16'($urandom_range(32769, 65535))});
                end_writes();
                for (int n = 0; n < ((round < 3) ? 60 : 12); n++) begin
                    // With no idling the sender keeps pushing into a held-off result side.
                    if (mode == 2 && round == 0 && n == 20) hold_ticket <= hold_ticket + 1;
                    if (round == 0 && n == 40) settle();
                    random_cmd();
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d commands across %0d register settings; %0d results checked.",
                 commands_sent, settings_used, checked);
        $display("Outcomes seen: %0d out of pages, %0d bad address, %0d double free.",
                 n_empty, n_bad_addr, n_double_free);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Timeout with %0d results still outstanding.", outstanding);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/bitmap_page_allocator.sv
sim/bpa_checker.sv
sim/bitmap_page_allocator_test.sv
